>>> src/free_extent_allocator_core_macros.svh
// assertion macros for the free extent allocator checker
// used by the checker bound to free_extent_allocator_core; needs i_clk and i_rst_n in scope
`ifndef FREE_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define FREE_EXTENT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FEA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("free extent allocator check failed");

// next-cycle implication, disabled during reset
`define FEA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("free extent allocator check failed");

`endif

>>> src/fea_pkg.sv
// shared types and constants of the free extent allocator
// no dependencies; imported by fea_cell, free_extent_allocator_core and fea_checker
package fea_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int PAGE_BITS   = 36;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int LEN_W       = PAGE_BITS + 1;
    localparam int SUM_W       = PAGE_BITS + 2;

    localparam logic [SUM_W-1:0] ALIGN_2M_PAGES = SUM_W'(512);
    localparam logic [SUM_W-1:0] ALIGN_1G_PAGES = SUM_W'(512 * 512);
    localparam logic [SUM_W-1:0] SPACE_PAGES    = SUM_W'(1) << PAGE_BITS;

    localparam logic [1:0] OP_FIXED = 2'd0;
    localparam logic [1:0] OP_ANY   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_OVERLAP = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ROT,
        CMD_WRITE,
        CMD_INS,
        CMD_DEL
    } t_cmd_kind;

    typedef struct packed {
        logic [PAGE_BITS-1:0] start;
        logic [LEN_W-1:0]     len;
    } t_ent;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] idx;
        t_ent             ent;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY1,
        S_APPLY2
    } t_state;

endpackage

>>> src/fea_cell.sv
// one slot of the extent table: holds one extent and trades it with its neighbors
// depends on fea_pkg
module fea_cell import fea_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cmd             i_cmd,
    input  t_ent             i_next,
    input  t_ent             i_prev,
    output t_ent             o_ent
);

    t_ent r_ent;
    t_ent n_ent;

    // select what this slot holds next
    always_comb begin
        n_ent = r_ent;
        case (i_cmd.kind)
            CMD_ROT: n_ent = i_next;
            CMD_DEL: begin
                if (i_idx >= i_cmd.idx) n_ent = i_next;
            end
            CMD_INS: begin
                if (i_idx > i_cmd.idx) n_ent = i_prev;
                else if (i_idx == i_cmd.idx) n_ent = i_cmd.ent;
            end
            CMD_WRITE: begin
                if (i_idx == i_cmd.idx) n_ent = i_cmd.ent;
            end
            default: n_ent = r_ent;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

>>> src/free_extent_allocator_core.sv
// free extent allocator: sorted table of free extents held in a ring of cells
// depends on fea_pkg and fea_cell
//
//  channel  | ports                                        | handshake
//  request  | i_operation, i_start_page, i_page_count      | i_start high, o_busy low
//  result   | o_status, o_granted_page, o_free_pages_total | o_valid, one cycle
//
// every request runs through scan, decide and apply states from accept to result strobe:
// the ring rotates once past the head cell, which a two-stage compare watches,
// then the decide state and the apply states S_APPLY1 and S_APPLY2 that shift or write the cells
// o_busy stays high from accept until the strobe; the strobe cycle already accepts
// reset clears count and free total; cell contents are not reset
module free_extent_allocator_core import fea_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_operation,
    input  logic [PAGE_BITS-1:0] i_start_page,
    input  logic [LEN_W-1:0]     i_page_count,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [PAGE_BITS-1:0] o_granted_page,
    output logic [LEN_W-1:0]     o_free_pages_total
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_count;
    logic [LEN_W-1:0]     r_total;
    logic [1:0]           r_op;
    logic [PAGE_BITS-1:0] r_p;
    logic [LEN_W-1:0]     r_n;
    logic [SUM_W-1:0]     r_pn;
    logic [SUM_W-1:0]     r_al;
    logic                 r_valid;
    t_status              r_status;
    logic [PAGE_BITS-1:0] r_grant;
    t_cmd                 r_op1, r_op2;

    // head stage
    logic                 r_a_v, r_a_live;
    logic [IDX_W-1:0]     r_a_idx;
    logic [PAGE_BITS-1:0] r_a_s;
    logic [LEN_W-1:0]     r_a_len;
    logic [SUM_W-1:0]     r_a_e, r_a_al;

    // recorded matches
    logic                 r_hit, r_fb, r_fnd, r_pv;
    logic [IDX_W-1:0]     r_hidx, r_fidx;
    logic [CNT_W-1:0]     r_nidx;
    logic [PAGE_BITS-1:0] r_hs, r_fs, r_ns, r_ps;
    logic [LEN_W-1:0]     r_hlen, r_flen, r_nlen, r_plen;
    logic [SUM_W-1:0]     r_he, r_fe, r_pe, r_hpos;

    t_ent w_cell [MAX_EXTENTS];
    t_cmd w_cmd;
    logic accept;

    assign accept = i_start && (r_state == S_IDLE);

    // ring of cells
    for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
        fea_cell u_cell (
            .i_clk  (i_clk),
            .i_idx  (IDX_W'(k)),
            .i_cmd  (w_cmd),
            .i_next (w_cell[(k + 1) % MAX_EXTENTS]),
            .i_prev (w_cell[(k + MAX_EXTENTS - 1) % MAX_EXTENTS]),
            .o_ent  (w_cell[k])
        );
    end

    // command broadcast to the cells
    always_comb begin
        w_cmd      = '0;
        w_cmd.kind = CMD_NOP;
        if (r_state == S_SCAN && r_cnt < CNT_W'(MAX_EXTENTS)) w_cmd.kind = CMD_ROT;
        else if (r_state == S_APPLY1) w_cmd = r_op1;
        else if (r_state == S_APPLY2) w_cmd = r_op2;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (r_cnt == CNT_W'(MAX_EXTENTS)) n_state = S_DECIDE;
            S_DECIDE: n_state = S_APPLY1;
            S_APPLY1: n_state = S_APPLY2;
            S_APPLY2: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // request capture and scan counter
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_operation;
            r_p  <= i_start_page;
            r_n  <= i_page_count;
            r_pn <= SUM_W'(i_start_page) + SUM_W'(i_page_count);
            if (SUM_W'(i_page_count) >= ALIGN_1G_PAGES) r_al <= ALIGN_1G_PAGES;
            else if (SUM_W'(i_page_count) >= ALIGN_2M_PAGES) r_al <= ALIGN_2M_PAGES;
            else r_al <= SUM_W'(1);
        end
        if (!i_rst_n) r_cnt <= '0;
        else if (accept) r_cnt <= '0;
        else if (r_state == S_SCAN) r_cnt <= r_cnt + CNT_W'(1);
    end

    // head stage: end and aligned start of the extent in cell 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else r_a_v <= (r_state == S_SCAN) && (r_cnt < CNT_W'(MAX_EXTENTS));
        r_a_live <= r_cnt < r_count;
        r_a_idx  <= r_cnt[IDX_W-1:0];
        r_a_s    <= w_cell[0].start;
        r_a_len  <= w_cell[0].len;
        r_a_e    <= SUM_W'(w_cell[0].start) + SUM_W'(w_cell[0].len);
        r_a_al   <= (SUM_W'(w_cell[0].start) + r_al - SUM_W'(1)) & ~(r_al - SUM_W'(1));
    end

    // compare stage
    logic b_fix, b_fit, b_ahit, b_before;
    always_comb begin
        b_fix    = (SUM_W'(r_a_s) <= SUM_W'(r_p)) && (r_pn <= r_a_e);
        b_fit    = r_n <= r_a_len;
        b_ahit   = b_fit && (SUM_W'(r_a_len) >= r_al) && (r_a_al < r_a_e)
                   && (r_a_al + SUM_W'(r_n) <= r_a_e);
        b_before = r_a_s < r_p;
    end

    // record first matches, and for a free the last extent before it, while the ring goes by
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit <= 1'b0;
            r_fb  <= 1'b0;
            r_fnd <= 1'b0;
            r_pv  <= 1'b0;
        end else if (r_a_v && r_a_live) begin
            case (r_op)
                OP_FIXED: begin
                    if (!r_hit && b_fix) begin
                        r_hit <= 1'b1; r_hidx <= r_a_idx; r_hs <= r_a_s;
                        r_hlen <= r_a_len; r_he <= r_a_e; r_hpos <= SUM_W'(r_p);
                    end
                end
                OP_ANY: begin
                    if (!r_hit && b_ahit) begin
                        r_hit <= 1'b1; r_hidx <= r_a_idx; r_hs <= r_a_s;
                        r_hlen <= r_a_len; r_he <= r_a_e; r_hpos <= r_a_al;
                    end
                    if (!r_fb && b_fit) begin
                        r_fb <= 1'b1; r_fidx <= r_a_idx; r_fs <= r_a_s;
                        r_flen <= r_a_len; r_fe <= r_a_e;
                    end
                end
                OP_FREE: begin
                    if (!r_fnd) begin
                        if (b_before) begin
                            r_pv <= 1'b1; r_ps <= r_a_s; r_plen <= r_a_len; r_pe <= r_a_e;
                        end else begin
                            r_fnd <= 1'b1; r_nidx <= CNT_W'(r_a_idx);
                            r_ns <= r_a_s; r_nlen <= r_a_len;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // decide status and table edits
    t_status              d_status;
    logic [PAGE_BITS-1:0] d_grant;
    t_cmd                 d_op1, d_op2;
    logic                 d_sub, d_add;
    logic                 t_sel, t_useh, full;
    logic [IDX_W-1:0]     t_idx, f_idx;
    logic [PAGE_BITS-1:0] t_s;
    logic [LEN_W-1:0]     t_len;
    logic [SUM_W-1:0]     t_e, t_pos, t_posn;
    logic [CNT_W-1:0]     f_cidx;
    logic                 jp, jn;
    always_comb begin
        d_status   = ST_NOFIT;
        d_grant    = '0;
        d_op1      = '0;
        d_op1.kind = CMD_NOP;
        d_op2      = '0;
        d_op2.kind = CMD_NOP;
        d_sub      = 1'b0;
        d_add      = 1'b0;
        full       = r_count >= CNT_W'(MAX_EXTENTS);
        t_useh     = r_hit;
        t_sel      = r_hit || (r_op == OP_ANY && r_fb);
        t_idx      = t_useh ? r_hidx : r_fidx;
        t_s        = t_useh ? r_hs : r_fs;
        t_len      = t_useh ? r_hlen : r_flen;
        t_e        = t_useh ? r_he : r_fe;
        t_pos      = t_useh ? r_hpos : SUM_W'(r_fs);
        t_posn     = t_pos + SUM_W'(r_n);
        f_cidx     = r_fnd ? r_nidx : r_count;
        f_idx      = f_cidx[IDX_W-1:0];
        jp         = r_pv && (r_pe == SUM_W'(r_p));
        jn         = r_fnd && (r_pn == SUM_W'(r_ns));
        case (r_op)
            OP_FIXED, OP_ANY: begin
                if (r_n != '0 && t_sel) begin
                    d_status = ST_OK;
                    d_sub    = 1'b1;
                    d_grant  = t_pos[PAGE_BITS-1:0];
                    if (t_pos == SUM_W'(t_s) && r_n == t_len) begin
                        d_op1.kind = CMD_DEL;
                        d_op1.idx  = t_idx;
                    end else if (t_pos == SUM_W'(t_s)) begin
                        d_op1.kind      = CMD_WRITE;
                        d_op1.idx       = t_idx;
                        d_op1.ent.start = t_posn[PAGE_BITS-1:0];
                        d_op1.ent.len   = t_len - r_n;
                    end else if (t_posn == t_e) begin
                        d_op1.kind      = CMD_WRITE;
                        d_op1.idx       = t_idx;
                        d_op1.ent.start = t_s;
                        d_op1.ent.len   = LEN_W'(t_pos - SUM_W'(t_s));
                    end else if (full) begin
                        d_status = ST_FULL;
                        d_sub    = 1'b0;
                        d_grant  = '0;
                    end else begin
                        d_op1.kind      = CMD_WRITE;
                        d_op1.idx       = t_idx;
                        d_op1.ent.start = t_s;
                        d_op1.ent.len   = LEN_W'(t_pos - SUM_W'(t_s));
                        d_op2.kind      = CMD_INS;
                        d_op2.idx       = t_idx + IDX_W'(1);
                        d_op2.ent.start = t_posn[PAGE_BITS-1:0];
                        d_op2.ent.len   = LEN_W'(t_e - t_posn);
                    end
                end
            end
            OP_FREE: begin
                if (r_n == '0) begin
                    d_status = ST_OK;
                end else if (r_pn > SPACE_PAGES
                             || (r_pv && r_pe > SUM_W'(r_p))
                             || (r_fnd && r_pn > SUM_W'(r_ns))) begin
                    d_status = ST_OVERLAP;
                end else if (jp) begin
                    d_status        = ST_OK;
                    d_add           = 1'b1;
                    d_op1.kind      = CMD_WRITE;
                    d_op1.idx       = f_idx - IDX_W'(1);
                    d_op1.ent.start = r_ps;
                    d_op1.ent.len   = r_plen + r_n + (jn ? r_nlen : LEN_W'(0));
                    if (jn) begin
                        d_op2.kind = CMD_DEL;
                        d_op2.idx  = f_idx;
                    end
                end else if (jn) begin
                    d_status        = ST_OK;
                    d_add           = 1'b1;
                    d_op1.kind      = CMD_WRITE;
                    d_op1.idx       = f_idx;
                    d_op1.ent.start = r_p;
                    d_op1.ent.len   = r_nlen + r_n;
                end else if (full) begin
                    d_status = ST_FULL;
                end else begin
                    d_status        = ST_OK;
                    d_add           = 1'b1;
                    d_op1.kind      = CMD_INS;
                    d_op1.idx       = f_idx;
                    d_op1.ent.start = r_p;
                    d_op1.ent.len   = r_n;
                end
            end
            default: ;
        endcase
    end

    // result, totals and extent count
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            r_status <= d_status;
            r_grant  <= d_grant;
            r_op1    <= d_op1;
            r_op2    <= d_op2;
        end
        if (!i_rst_n) begin
            r_total <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_APPLY2);
            if (r_state == S_DECIDE) begin
                if (d_sub) r_total <= r_total - r_n;
                else if (d_add) r_total <= r_total + r_n;
            end
            if (w_cmd.kind == CMD_INS) r_count <= r_count + CNT_W'(1);
            else if (w_cmd.kind == CMD_DEL) r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_granted_page     = r_grant;
    assign o_free_pages_total = r_total;

endmodule

>>> src/fea_checker.sv
// port-level checks for free_extent_allocator_core, bound to the top level
// depends on fea_pkg and free_extent_allocator_core_macros.svh
`include "free_extent_allocator_core_macros.svh"

module fea_checker import fea_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic                 o_valid,
    input logic [1:0]           o_status,
    input logic [PAGE_BITS-1:0] o_granted_page
);

    // an accepted request keeps the block busy
    `FEA_ASSERT_NXT(a_accept_busy, i_start && !o_busy, o_busy)
    // no result follows an accept directly
    `FEA_ASSERT_NXT(a_no_early_result, i_start && !o_busy, !o_valid)
    // a result closes the busy period
    `FEA_ASSERT_IMP(a_result_idle, o_valid, !o_busy && $past(o_busy))
    // failed requests grant nothing
    `FEA_ASSERT_IMP(a_fail_no_grant, o_valid && o_status != ST_OK, o_granted_page == '0)

endmodule

bind free_extent_allocator_core fea_checker u_fea_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_granted_page (o_granted_page)
);
